// ===== sv/mish_activation_top_defines.svh =====
// ----------------------------------------------------------------------------
// Mish activation assertion macros
// Shared property wrappers for the checker of the Mish activation unit.
// ----------------------------------------------------------------------------
`ifndef MISH_ACTIVATION_TOP_DEFINES_SVH
`define MISH_ACTIVATION_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define MA_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define MA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/mish_act_pkg.sv =====
// ----------------------------------------------------------------------------
// Mish activation package
// Formats, sideband type and exponential lookup tables built at elaboration.
// ----------------------------------------------------------------------------
package mish_act_pkg;

  localparam int unsigned DATA_W     = 16;
  localparam int unsigned FRAC_W     = 10;
  localparam int unsigned MAG_W      = DATA_W + 1;
  localparam int unsigned INT_W      = MAG_W - FRAC_W;
  localparam int unsigned SEG_W      = 5;
  localparam int unsigned TAB_DEPTH  = 1 << SEG_W;
  localparam int unsigned TQ         = 32;
  localparam int unsigned TV_W       = TQ + 1;
  localparam int unsigned DEN_W      = TQ + 3;
  localparam int unsigned DIV_STAGES = TQ / 2;
  localparam int unsigned PROD_W     = MAG_W + TV_W;

  typedef logic [TV_W-1:0] fix_t;
  typedef fix_t [TAB_DEPTH-1:0] exp_tab_t;

  typedef struct packed {
    logic             last;
    logic             neg;
    logic             one;
    logic [MAG_W-1:0] mag;
  } tag_t;

  localparam logic [63:0] Q62_ONE = 64'd1 << 62;

  // e^-(1/1024) in Q62 from a six-term series
  localparam logic [63:0] E_STEP = (64'd1 << 62) - (64'd1 << 52) + (64'd1 << 41)
                                 - ((64'd1 << 32) / 6) + ((64'd1 << 22) / 24)
                                 - ((64'd1 << 12) / 120);

  function automatic logic [63:0] q62_mul(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  function automatic logic [63:0] q62_pow(logic [63:0] base, int unsigned n);
    logic [63:0] acc;
    acc = Q62_ONE;
    for (int unsigned k = 0; k < n; k++) begin
      acc = q62_mul(acc, base);
    end
    return acc;
  endfunction

  function automatic exp_tab_t exp_table(logic [63:0] base);
    exp_tab_t    tab;
    logic [63:0] acc;
    logic [63:0] rnd;
    acc = Q62_ONE;
    for (int unsigned k = 0; k < TAB_DEPTH; k++) begin
      rnd    = acc + (64'd1 << 29);
      tab[k] = rnd[62:30];
      acc    = q62_mul(acc, base);
    end
    return tab;
  endfunction

  localparam logic [63:0] E_SEG  = q62_pow(E_STEP, TAB_DEPTH);
  localparam logic [63:0] E_UNIT = q62_pow(E_SEG, TAB_DEPTH);

  // e^-k/1024, e^-k/32 and e^-k in Q32
  localparam exp_tab_t TAB_FL = exp_table(E_STEP);
  localparam exp_tab_t TAB_FH = exp_table(E_SEG);
  localparam exp_tab_t TAB_N  = exp_table(E_UNIT);

endpackage

// ===== sv/mish_activation_top.sv =====
// ----------------------------------------------------------------------------
// Mish activation unit
// y = x * tanh(ln(1 + e^x)) on signed Q5.10 items, last flag passed along.
// Throughput: one item per cycle while the output is not stalled; the 16-stage divider sets the depth.
// The whole pipeline holds while a result waits on the output.
// Reset clears all valid bits; the datapath registers are not reset.
// ----------------------------------------------------------------------------
module mish_activation_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [mish_act_pkg::DATA_W-1:0]  s_axis_tdata_i,  // [15:0] x_value
  input  logic                             s_axis_tlast_i,  // last_in
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  output logic [mish_act_pkg::DATA_W-1:0]  m_axis_tdata_o,  // [15:0] y_value
  output logic                             m_axis_tlast_o   // last_out
);
  import mish_act_pkg::*;

  logic ce;

  logic              v0_q, v1_q, v2_q, v3_q, v4_q, v5_q, vp_q, vo_q;
  logic [DATA_W-1:0] x0_q;
  logic              last0_q;
  tag_t              tag1_q, tag2_q, tag3_q, tag4_q, tag5_q, tagp_q;
  fix_t              tn1_q, tfh1_q, tfl1_q, tn2_q, p2_q, u3_q, u4_q, sq4_q;
  logic [DEN_W-1:0]  num5_q, den5_q;
  logic [PROD_W-1:0] prod_q;
  logic [DATA_W-1:0] y_q;
  logic              last_q;

  logic              neg;
  logic [MAG_W-1:0]  xs;
  logic [MAG_W-1:0]  mag;
  logic [INT_W-1:0]  nint;
  logic              big;
  tag_t              tag1_d;
  logic [2*TV_W-1:0] mul2, mul3, mul4;
  logic [DEN_W-1:0]  num5_d, den5_d;
  tag_t              tag5_d;
  logic              vdiv;
  logic [TQ-1:0]     quo;
  tag_t              tagd;
  fix_t              th;
  logic [PROD_W-1:0] prod_d;
  logic [PROD_W-1:0] rsum;
  logic [PROD_W-TQ-1:0] ymag;
  logic [PROD_W-TQ-1:0] yval;

  assign ce              = !vo_q || m_axis_tready_i;
  assign s_axis_tready_o = ce;

  // split the magnitude into integer, upper and lower fraction segments
  always_comb begin
    neg    = x0_q[DATA_W-1];
    xs     = {x0_q[DATA_W-1], x0_q};
    mag    = neg ? (~xs + MAG_W'(1)) : xs;
    nint   = mag[MAG_W-1:FRAC_W];
    big    = |nint[INT_W-1:SEG_W];
    tag1_d = '{last: last0_q, neg: neg, one: 1'b0, mag: mag};
  end

  assign mul2 = {{(TV_W){1'b0}}, tfh1_q} * {{(TV_W){1'b0}}, tfl1_q};
  assign mul3 = {{(TV_W){1'b0}}, tn2_q} * {{(TV_W){1'b0}}, p2_q};
  assign mul4 = {{(TV_W){1'b0}}, u3_q} * {{(TV_W){1'b0}}, u3_q};

  // tanh(softplus) as a quotient of terms in u = e^-|x|
  always_comb begin
    tag5_d = tag4_q;
    if (tag4_q.neg) begin
      num5_d = {2'b00, sq4_q} + {1'b0, u4_q, 1'b0};
      den5_d = num5_d + (DEN_W'(1) << (TQ + 1));
    end else begin
      num5_d = (DEN_W'(1) << TQ) + {1'b0, u4_q, 1'b0};
      den5_d = num5_d + {1'b0, sq4_q, 1'b0};
    end
    tag5_d.one = (num5_d == den5_d);
  end

  mish_act_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (ce),
    .valid_i (v5_q),
    .num_i   (num5_q),
    .den_i   (den5_q),
    .tag_i   (tag5_q),
    .valid_o (vdiv),
    .quo_o   (quo),
    .tag_o   (tagd)
  );

  always_comb begin
    th     = tagd.one ? (TV_W'(1) << TQ) : {1'b0, quo};
    prod_d = {{(TV_W){1'b0}}, tagd.mag} * {{(MAG_W){1'b0}}, th};
    rsum   = prod_q + (PROD_W'(1) << (TQ - 1));
    ymag   = rsum[PROD_W-1:TQ];
    yval   = tagp_q.neg ? (~ymag + (PROD_W-TQ)'(1)) : ymag;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      vp_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (ce) begin
      v0_q <= s_axis_tvalid_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      vp_q <= vdiv;
      vo_q <= vp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      x0_q    <= s_axis_tdata_i;
      last0_q <= s_axis_tlast_i;
      tag1_q  <= tag1_d;
      tn1_q   <= big ? '0 : TAB_N[nint[SEG_W-1:0]];
      tfh1_q  <= TAB_FH[mag[FRAC_W-1:SEG_W]];
      tfl1_q  <= TAB_FL[mag[SEG_W-1:0]];
      tag2_q  <= tag1_q;
      tn2_q   <= tn1_q;
      p2_q    <= mul2[TQ +: TV_W];
      tag3_q  <= tag2_q;
      u3_q    <= mul3[TQ +: TV_W];
      tag4_q  <= tag3_q;
      u4_q    <= u3_q;
      sq4_q   <= mul4[TQ +: TV_W];
      tag5_q  <= tag5_d;
      num5_q  <= num5_d;
      den5_q  <= den5_d;
      tagp_q  <= tagd;
      prod_q  <= prod_d;
      y_q     <= yval[DATA_W-1:0];
      last_q  <= tagp_q.last;
    end
  end

  assign m_axis_tvalid_o = vo_q;
  assign m_axis_tdata_o  = y_q;
  assign m_axis_tlast_o  = last_q;

endmodule

// ===== sv/mish_act_div.sv =====
// ----------------------------------------------------------------------------
// Mish activation divider
// Pipelined restoring divider, two quotient bits per stage, sideband carried.
// ----------------------------------------------------------------------------
module mish_act_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic [mish_act_pkg::DEN_W-1:0]      num_i,
  input  logic [mish_act_pkg::DEN_W-1:0]      den_i,
  input  mish_act_pkg::tag_t                  tag_i,
  output logic                                valid_o,
  output logic [mish_act_pkg::TQ-1:0]         quo_o,
  output mish_act_pkg::tag_t                  tag_o
);
  import mish_act_pkg::*;

  logic                  v_q   [DIV_STAGES];
  logic [DEN_W-1:0]      r_q   [DIV_STAGES];
  logic [DEN_W-1:0]      d_q   [DIV_STAGES];
  logic [TQ-1:0]         q_q   [DIV_STAGES];
  tag_t                  t_q   [DIV_STAGES];
  logic [DEN_W-1:0]      r_d   [DIV_STAGES];
  logic [TQ-1:0]         q_d   [DIV_STAGES];
  logic                  v_in  [DIV_STAGES];
  logic [DEN_W-1:0]      r_in  [DIV_STAGES];
  logic [DEN_W-1:0]      d_in  [DIV_STAGES];
  logic [TQ-1:0]         q_in  [DIV_STAGES];
  tag_t                  t_in  [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    if (s == 0) begin : g_first
      assign v_in[s] = valid_i;
      assign r_in[s] = num_i;
      assign d_in[s] = den_i;
      assign q_in[s] = '0;
      assign t_in[s] = tag_i;
    end else begin : g_next
      assign v_in[s] = v_q[s-1];
      assign r_in[s] = r_q[s-1];
      assign d_in[s] = d_q[s-1];
      assign q_in[s] = q_q[s-1];
      assign t_in[s] = t_q[s-1];
    end

    always_comb begin
      logic [DEN_W:0] r1;
      logic [DEN_W:0] r2;
      logic [DEN_W:0] dx;
      logic           b1;
      logic           b2;
      dx = {1'b0, d_in[s]};
      r1 = {r_in[s], 1'b0};
      b1 = (r1 >= dx);
      if (b1) begin
        r1 = r1 - dx;
      end
      r2 = {r1[DEN_W-1:0], 1'b0};
      b2 = (r2 >= dx);
      if (b2) begin
        r2 = r2 - dx;
      end
      r_d[s] = r2[DEN_W-1:0];
      q_d[s] = {q_in[s][TQ-3:0], b1, b2};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i) begin
        v_q[s] <= v_in[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[s] <= r_d[s];
        d_q[s] <= d_in[s];
        q_q[s] <= q_d[s];
        t_q[s] <= t_in[s];
      end
    end
  end

  assign valid_o = v_q[DIV_STAGES-1];
  assign quo_o   = q_q[DIV_STAGES-1];
  assign tag_o   = t_q[DIV_STAGES-1];

endmodule

// ===== sv/mish_act_chk.sv =====
// ----------------------------------------------------------------------------
// Mish activation port checker
// Watches the stream ports of the Mish activation unit over time.
// ----------------------------------------------------------------------------
`include "mish_activation_top_defines.svh"

module mish_act_chk (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tready_o,
  input logic                             m_axis_tvalid_o,
  input logic                             m_axis_tready_i,
  input logic [mish_act_pkg::DATA_W-1:0]  m_axis_tdata_o,
  input logic                             m_axis_tlast_o
);

  `MA_ASSERT_NOW(a_ready_follows_stall, clk_i, rst_ni, 1'b1, s_axis_tready_o == (!m_axis_tvalid_o || m_axis_tready_i), "input ready does not follow output stall")
  `MA_ASSERT_NOW(a_no_item_after_reset, clk_i, rst_ni, $rose(rst_ni), !m_axis_tvalid_o, "output item present right after reset")
  `MA_ASSERT_NEXT(a_valid_holds, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o, "output item dropped while stalled")
  `MA_ASSERT_NEXT(a_payload_holds, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o), "output payload changed while stalled")

endmodule

bind mish_activation_top mish_act_chk u_mish_act_chk (.*);

// ===== test/mish_activation_top_test.sv =====
// ----------------------------------------------------------------------------
// Mish activation unit testbench
// Streams Q5.10 elements through the unit and checks each result against a
// fixed-point Mish predictor built on Q4.60 series and division arithmetic.
// The result value may differ from the prediction by at most one LSB, and
// the last flag must match exactly. Both stream sides idle at random.
// One long output stall fills the pipeline, and one pause lets it drain.
// ----------------------------------------------------------------------------
module mish_activation_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned XW = mish_act_pkg::DATA_W;
  localparam int unsigned FX_FRAC = 60;
  localparam logic [63:0] FX_ONE = 64'd1 << FX_FRAC;

  typedef struct packed {
    logic [XW-1:0] y;
    logic          last;
  } mish_result_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          s_axis_tvalid_i = 1'b0;
  logic          s_axis_tready_o;
  logic [XW-1:0] s_axis_tdata_i = '0;
  logic          s_axis_tlast_i = 1'b0;
  logic          m_axis_tvalid_o;
  logic          m_axis_tready_i = 1'b0;
  logic [XW-1:0] m_axis_tdata_o;
  logic          m_axis_tlast_o;

  mish_result_t pending_results[$];
  int           mismatch_count = 0;
  bit           idle_on = 1'b1;
  int           sink_hold = 0;

  mish_activation_top u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [63:0] fx_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  function automatic logic [63:0] exp_neg_fraction(input logic [63:0] f);
    logic [63:0] acc;
    logic [63:0] term;
    logic [6:0]  k;
    acc  = FX_ONE;
    term = FX_ONE;
    for (k = 1; k <= 30; k++) begin
      term = fx_mul(term, f) / k;
      if (k[0]) begin
        acc = acc - term;
      end else begin
        acc = acc + term;
      end
    end
    return acc;
  endfunction

  function automatic logic [63:0] fx_div(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [63:0] r;
    if (num >= den) return FX_ONE;
    q = '0;
    r = num;
    for (int i = 0; i < FX_FRAC; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [XW-1:0] mish_predict(input logic [XW-1:0] x);
    logic        neg;
    logic [16:0] mag;
    logic [6:0]  n;
    logic [63:0] e;
    logic [63:0] e_one;
    logic [63:0] num;
    logic [63:0] th;
    logic [63:0] ymag;
    neg = x[15];
    mag = neg ? (17'h10000 - {1'b0, x}) : {1'b0, x};
    n   = mag[16:10];
    if (n > 63) begin
      e = '0;
    end else begin
      e_one = exp_neg_fraction(FX_ONE);
      e     = exp_neg_fraction({54'd0, mag[9:0]} << 50);
      for (int i = 0; i < n && e != 0; i++) begin
        e = fx_mul(e, e_one);
      end
    end
    if (neg) begin
      num = fx_mul(e, e + (FX_ONE << 1));
      th  = fx_div(num, num + (FX_ONE << 1));
    end else begin
      num = FX_ONE + (e << 1);
      th  = fx_div(num, num + (fx_mul(e, e) << 1));
    end
    ymag = (fx_mul({46'd0, mag, 1'b0}, th) + 64'd1) >> 1;
    if (neg) ymag = 64'd0 - ymag;
    return ymag[15:0];
  endfunction

  task automatic send_element(input logic [XW-1:0] x, input logic last);
    mish_result_t r;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= x;
    s_axis_tlast_i  <= last;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    r.y    = mish_predict(x);
    r.last = last;
    pending_results.push_back(r);
  endtask

  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  initial begin : sink
    forever begin
      @(posedge clk_i);
      if (sink_hold > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (sink_hold) @(posedge clk_i);
        sink_hold = 0;
        m_axis_tready_i <= 1'b1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
        m_axis_tready_i <= 1'b1;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    mish_result_t want;
    int           dy;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected item y=%0d last=%0b", $time,
                 $signed(m_axis_tdata_o), m_axis_tlast_o);
      end else begin
        want = pending_results.pop_front();
        dy   = int'($signed(m_axis_tdata_o)) - int'($signed(want.y));
        if (dy > 1 || dy < -1) begin
          mismatch_count++;
          $display("%0t: y mismatch expected %0d actual %0d", $time,
                   $signed(want.y), $signed(m_axis_tdata_o));
        end
        if (m_axis_tlast_o !== want.last) begin
          mismatch_count++;
          $display("%0t: last mismatch expected %0b actual %0b", $time,
                   want.last, m_axis_tlast_o);
        end
      end
    end
  end

  task automatic test_directed();
    logic [XW-1:0] corner[$];
    corner = {16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h0400,
              16'hFC00, 16'h0200, 16'hFE00, 16'h0800, 16'hF400, 16'h2800,
              16'hD800, 16'h5555, 16'hAAAA, 16'hFA00, 16'h7C00, 16'h8400,
              16'h0064, 16'hFF9C, 16'h1388, 16'hEC78, 16'h03FF};
    send_element(16'h0000, 1'b1);
    foreach (corner[i]) send_element(corner[i], i[0]);
  endtask

  task automatic test_random_elements(input int count);
    logic [XW-1:0] x;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) < 7) begin
        x = XW'($urandom_range(0, 12287));
        if ($urandom_range(0, 1)) x = -x;
      end else begin
        x = XW'($urandom);
      end
      send_element(x, $urandom_range(0, 15) == 0);
    end
  endtask

  task automatic test_output_stall();
    sink_hold = 200;
    test_random_elements(60);
    wait_drained();
  endtask

  task automatic test_drain_pause();
    test_random_elements(20);
    wait_drained();
    test_random_elements(20);
  endtask

  task automatic test_streaming();
    idle_on = 1'b0;
    test_random_elements(40);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_elements(290);
    test_output_stall();
    test_drain_pause();
    test_streaming();
    wait_drained();
    repeat (40) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
